FILE: hw/rtl/mmm_pkg.sv
// Shared types, register indexes and the motor mix function of the motor mixer.
// Used by every mixer module but the checker; depends on nothing.
package mmm_pkg;

    localparam int unsigned MotW   = 14;
    localparam int unsigned OutW   = 13;
    localparam int unsigned CmdW   = 11;
    localparam int unsigned NumW   = 16;
    localparam int unsigned DenW   = 13;
    localparam int unsigned QW     = 9;
    localparam int unsigned QDepth = 4;
    localparam logic [12:0] Recip10 = 13'd6554;

    typedef enum logic [2:0] {
        REG_AIRFRAME = 3'd0,
        REG_IDLE     = 3'd1,
        REG_MAX      = 3'd2,
        REG_YAW_SENSE = 3'd3,
        REG_BALANCE  = 3'd4,
        REG_NEUTRAL  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        AF_QUAD = 2'd0,
        AF_TRI  = 2'd1,
        AF_Y6   = 2'd2,
        AF_HEXA = 2'd3
    } t_airframe;

    typedef logic signed [MotW-1:0] t_mot;
    typedef t_mot t_mix [6];

    typedef struct packed {
        logic [1:0]        airframe;
        logic [7:0]        idle;
        logic [7:0]        max_out;
        logic signed [1:0] yaw_sense;
        logic signed [7:0] balance;
        logic [7:0]        neutral;
    } t_cfg;

    typedef struct packed {
        logic [7:0]             t;
        logic signed [CmdW-1:0] r;
        logic signed [CmdW-1:0] p;
        logic signed [CmdW-1:0] y;
        logic                   mixon;
    } t_job;

    typedef struct packed {
        t_job job;
        logic divon;
        logic neg;
    } t_djob;

    function automatic t_mix mmm_mix(input t_cfg cfg, input logic [7:0] t,
                                     input logic signed [CmdW-1:0] r,
                                     input logic signed [CmdW-1:0] p,
                                     input logic signed [CmdW-1:0] y,
                                     input logic mixon);
        logic [15:0] tt, rr, pp, yy, h, fr, lf, rt, srv, ysx;
        logic [9:0]  g;
        logic [25:0] prod;
        t_mix        m;
        tt   = {8'd0, t};
        rr   = {{(16-CmdW){r[CmdW-1]}}, r};
        pp   = {{(16-CmdW){p[CmdW-1]}}, p};
        yy   = {{(16-CmdW){y[CmdW-1]}}, y};
        h    = {pp[15], pp[15:1]};
        ysx  = {{14{cfg.yaw_sense[1]}}, cfg.yaw_sense};
        srv  = 16'(ysx * yy) + {8'd0, cfg.neutral};
        fr   = tt - pp;
        lf   = tt + h - rr;
        rt   = tt + h + rr;
        g    = {{2{cfg.balance[7]}}, cfg.balance} + 10'd128;
        prod = {{10{fr[15]}}, fr} * {{16{g[9]}}, g};
        for (int i = 0; i < 6; i++) begin
            m[i] = '0;
        end
        if (!mixon) begin
            for (int i = 0; i < 6; i++) begin
                if (i < 4 || cfg.airframe >= AF_Y6) begin
                    m[i] = tt[MotW-1:0];
                end
            end
            if (cfg.airframe == AF_TRI) begin
                m[3] = srv[MotW-1:0];
            end
        end else begin
            case (cfg.airframe)
                AF_QUAD: begin
                    m[0] = MotW'(tt - pp + yy);
                    m[1] = MotW'(tt - rr - yy);
                    m[2] = MotW'(tt + rr - yy);
                    m[3] = MotW'(tt + pp + yy);
                end
                AF_TRI: begin
                    m[0] = (cfg.balance != 8'sd0) ? prod[7+MotW-1:7] : fr[MotW-1:0];
                    m[1] = lf[MotW-1:0];
                    m[2] = rt[MotW-1:0];
                    m[3] = srv[MotW-1:0];
                end
                AF_Y6: begin
                    m[0] = MotW'(fr + yy);
                    m[1] = MotW'(lf + yy);
                    m[2] = MotW'(rt + yy);
                    m[3] = MotW'(fr - yy);
                    m[4] = MotW'(lf - yy);
                    m[5] = MotW'(rt - yy);
                end
                default: begin
                    m[0] = MotW'(tt - pp + (yy << 1));
                    m[1] = MotW'(tt + h - rr + (yy << 1));
                    m[2] = MotW'(tt + h + rr + (yy << 1));
                    m[3] = MotW'(tt + pp - (yy << 1));
                    m[4] = MotW'(tt - h - rr - (yy << 1));
                    m[5] = MotW'(tt - h + rr - (yy << 1));
                end
            endcase
        end
        return m;
    endfunction

endpackage

FILE: hw/rtl/mmm_front.sv
// Front end of the mixer: derives the working throttle and classifies the item.
// Depends on mmm_pkg.
module mmm_front (
    input  mmm_pkg::t_cfg        i_cfg,
    input  logic [7:0]           i_desired,
    input  logic signed [7:0]    i_alt_comp,
    input  logic                 i_in_flight,
    input  logic signed [10:0]   i_roll,
    input  logic signed [10:0]   i_pitch,
    input  logic signed [10:0]   i_yaw,
    output mmm_pkg::t_job        o_job
);
    import mmm_pkg::*;

    logic [11:0]       x9;
    logic [24:0]       hprod;
    logic [7:0]        hi;
    logic signed [9:0] sum;
    logic [7:0]        t;

    // Ninety percent of the maximum by a reciprocal multiply.
    assign x9    = {4'd0, i_cfg.max_out} * 12'd9;
    assign hprod = {13'd0, x9} * {12'd0, Recip10};
    assign hi    = hprod[23:16];
    assign sum   = $signed({2'b00, i_desired}) + {{2{i_alt_comp[7]}}, i_alt_comp};

    always_comb begin
        if (i_desired < i_cfg.idle) begin
            t = 8'd0;
        end else if (!i_in_flight) begin
            t = i_desired;
        end else if (sum < $signed({2'b00, i_cfg.idle})) begin
            t = i_cfg.idle;
        end else if (sum > $signed({2'b00, hi})) begin
            t = hi;
        end else begin
            t = sum[7:0];
        end
    end

    always_comb begin
        o_job.t     = t;
        o_job.r     = i_roll;
        o_job.p     = i_pitch;
        o_job.y     = i_yaw;
        o_job.mixon = (t > i_cfg.idle);
    end
endmodule

FILE: hw/rtl/mmm_queue.sv
// Short queue between the front end and the back end of the mixer.
// Depends on mmm_pkg.
module mmm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mmm_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mmm_pkg::t_job o_job
);
    import mmm_pkg::*;

    localparam int unsigned PW = $clog2(QDepth);

    t_job            r_mem [QDepth];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            wr, rd;

    assign o_full  = (r_cnt == (PW+1)'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(wr) - (PW+1)'(rd);
        end
    end
endmodule

FILE: hw/rtl/mmm_div.sv
// Pipelined restoring divider, one quotient bit per stage, nine stages.
// Quotients of 256 and more read with the top bit set. Depends on mmm_pkg.
module mmm_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  mmm_pkg::t_djob           i_job,
    input  logic [mmm_pkg::NumW-1:0] i_num,
    input  logic [mmm_pkg::DenW-1:0] i_den,
    output logic                     o_valid,
    output mmm_pkg::t_djob           o_job,
    output logic [mmm_pkg::QW-1:0]   o_q
);
    import mmm_pkg::*;

    localparam int unsigned CW = NumW + QW;

    logic            w_v   [QW+1];
    t_djob           w_job [QW+1];
    logic [NumW-1:0] w_rem [QW+1];
    logic [DenW-1:0] w_den [QW+1];
    logic [QW-1:0]   w_q   [QW+1];

    assign w_v[0]   = i_valid;
    assign w_job[0] = i_job;
    assign w_rem[0] = i_num;
    assign w_den[0] = i_den;
    assign w_q[0]   = '0;

    for (genvar g = 0; g < QW; g++) begin : g_stage
        localparam int unsigned K = QW - 1 - g;
        logic [CW-1:0]   sh;
        logic            ge;
        logic            r_v;
        t_djob           r_job;
        logic [NumW-1:0] r_rem;
        logic [DenW-1:0] r_den;
        logic [QW-1:0]   r_q;

        assign sh = CW'(w_den[g]) << K;
        assign ge = (CW'(w_rem[g]) >= sh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_job <= w_job[g];
                r_den <= w_den[g];
                r_rem <= ge ? (w_rem[g] - sh[NumW-1:0]) : w_rem[g];
                r_q   <= {w_q[g][QW-2:0], ge};
            end
        end

        assign w_v[g+1]   = r_v;
        assign w_job[g+1] = r_job;
        assign w_rem[g+1] = r_rem;
        assign w_den[g+1] = r_den;
        assign w_q[g+1]   = r_q;
    end

    assign o_valid = w_v[QW];
    assign o_job   = w_job[QW];
    assign o_q     = w_q[QW];
endmodule

FILE: hw/rtl/mmm_back.sv
// Back end of the mixer: first mix, headroom division, rescale and final mix.
// Depends on mmm_pkg and mmm_div.
module mmm_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mmm_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  mmm_pkg::t_job i_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [87:0]   o_data,
    output logic          o_rescaled
);
    import mmm_pkg::*;

    logic            en;
    t_mix            m1, mf;
    logic [15:0]     top, swing;
    logic signed [8:0] lim_h, lim_l, lim;
    logic [7:0]      lim_abs;
    t_djob           dj;

    logic            r_v0;
    t_djob           r_dj0;
    logic [NumW-1:0] r_num0;
    logic [DenW-1:0] r_den0;

    logic            dv;
    t_djob           dq;
    logic [QW-1:0]   q;

    logic            resc;
    logic [7:0]      s;
    logic [19:0]     pr_r, pr_p, pr_y;
    t_job            n_job1;

    logic            r_v1;
    t_job            r_job1;
    logic            r_resc1;

    logic            r_ov;
    logic [87:0]     r_data;
    logic            r_resc;

    // The whole back end advances together whenever the output word can move.
    assign en    = !r_ov || i_ready;
    assign o_pop = en;

    always_comb begin
        m1  = mmm_mix(i_cfg, i_job.t, i_job.r, i_job.p, i_job.y, i_job.mixon);
        top = 16'(m1[0]);
        for (int i = 1; i < 6; i++) begin
            if ((i < 3 || i_cfg.airframe != AF_TRI) && (i < 4 || i_cfg.airframe >= AF_Y6)
                && ($signed(16'(m1[i])) > $signed(top))) begin
                top = 16'(m1[i]);
            end
        end
        swing    = top - {8'd0, i_job.t};
        lim_h    = $signed({1'b0, i_cfg.max_out}) - $signed({1'b0, i_job.t});
        lim_l    = $signed({1'b0, i_job.t}) - $signed({1'b0, i_cfg.idle});
        lim      = (lim_h < lim_l) ? lim_h : lim_l;
        lim_abs  = lim[8] ? 8'(-lim) : lim[7:0];
        dj.job   = i_job;
        dj.divon = i_job.mixon && !swing[15] && (swing != 16'd0);
        dj.neg   = lim[8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dj0  <= dj;
            r_num0 <= {lim_abs, 8'd0};
            r_den0 <= swing[DenW-1:0];
        end
    end

    mmm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v0),
        .i_job   (r_dj0),
        .i_num   (r_num0),
        .i_den   (r_den0),
        .o_valid (dv),
        .o_job   (dq),
        .o_q     (q)
    );

    // A negative headroom gives a factor of one, or zero when its size times 256 is smaller than the swing.
    always_comb begin
        if (!dq.divon) begin
            resc = 1'b0;
            s    = 8'd0;
        end else if (dq.neg) begin
            resc = 1'b1;
            s    = (q != '0) ? 8'd1 : 8'd0;
        end else begin
            resc = !q[QW-1];
            s    = q[7:0];
        end
        pr_r = {{9{dq.job.r[10]}}, dq.job.r} * {12'd0, s};
        pr_p = {{9{dq.job.p[10]}}, dq.job.p} * {12'd0, s};
        pr_y = {{9{dq.job.y[10]}}, dq.job.y} * {12'd0, s};
        n_job1 = dq.job;
        if (resc) begin
            n_job1.r = pr_r[18:8];
            n_job1.p = pr_p[18:8];
            if (i_cfg.airframe != AF_TRI) begin
                n_job1.y = pr_y[18:8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_job1  <= n_job1;
            r_resc1 <= resc;
        end
    end

    assign mf = mmm_mix(i_cfg, r_job1.t, r_job1.r, r_job1.p, r_job1.y, r_job1.mixon);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_data <= {2'b00, r_job1.t, mf[5][OutW-1:0], mf[4][OutW-1:0],
                       mf[3][OutW-1:0], mf[2][OutW-1:0], mf[1][OutW-1:0],
                       mf[0][OutW-1:0]};
            r_resc <= r_resc1;
        end
    end

    assign o_valid    = r_ov;
    assign o_data     = r_data;
    assign o_rescaled = r_resc;
endmodule

FILE: hw/rtl/multirotor_motor_mixer_top.sv
// Top level of the multirotor motor mixer: configuration registers and the
// front end, queue and back end. Depends on mmm_pkg, mmm_front, mmm_queue and mmm_back.
//
// Usage: control updates enter on the s_axis channel, one word per update, and
// one result word leaves on m_axis for each. Configuration registers are written
// through the cfg channel (index, data), which is always ready; write them only
// while no update is in flight.
// An accepted input word enters the queue at the accepting edge,
// then passes one first-mix stage, nine divider stages (one quotient bit each),
// one rescale multiply stage and the output register. One word is accepted per
// cycle while the back end does not hold; the rate is set by the divider pipeline,
// which takes a new division every cycle in which the back end advances.
// When the receiver stalls, the whole back end holds, the four-entry queue
// fills, and s_axis_tready drops only when the queue is full.
// A synchronous reset empties the queue and the pipeline and loads the
// registers with quad plus, idle 20, maximum 210, yaw sense 1, balance 0 and
// servo neutral 105.
module multirotor_motor_mixer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // desired_throttle, alt_comp, roll_cmd, pitch_cmd, yaw_cmd, zero fill
    input  logic [55:0] s_axis_tdata,
    // in_flight
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // motor_a, motor_b, motor_c, motor_d, motor_e, motor_f, throttle_used, zero fill
    output logic [87:0] m_axis_tdata,
    // rescaled
    output logic        m_axis_tuser
);
    import mmm_pkg::*;

    t_cfg r_cfg;
    t_job fjob, qjob;
    logic full, qv, pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.airframe  <= AF_QUAD;
            r_cfg.idle      <= 8'd20;
            r_cfg.max_out   <= 8'd210;
            r_cfg.yaw_sense <= 2'sd1;
            r_cfg.balance   <= 8'sd0;
            r_cfg.neutral   <= 8'd105;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_AIRFRAME:  r_cfg.airframe  <= i_cfg_data[1:0];
                REG_IDLE:      r_cfg.idle      <= i_cfg_data;
                REG_MAX:       r_cfg.max_out   <= i_cfg_data;
                REG_YAW_SENSE: r_cfg.yaw_sense <= i_cfg_data[1:0];
                REG_BALANCE:   r_cfg.balance   <= i_cfg_data;
                REG_NEUTRAL:   r_cfg.neutral   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mmm_front u_front (
        .i_cfg       (r_cfg),
        .i_desired   (s_axis_tdata[7:0]),
        .i_alt_comp  (s_axis_tdata[15:8]),
        .i_in_flight (s_axis_tuser),
        .i_roll      (s_axis_tdata[26:16]),
        .i_pitch     (s_axis_tdata[37:27]),
        .i_yaw       (s_axis_tdata[48:38]),
        .o_job       (fjob)
    );

    assign s_axis_tready = !full;

    mmm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_job   (fjob),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (qv),
        .o_job   (qjob)
    );

    mmm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (qv),
        .i_job      (qjob),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata),
        .o_rescaled (m_axis_tuser)
    );
endmodule

FILE: hw/rtl/mmm_checker.sv
// Port-level checks for the motor mixer, bound to the top level.
// Depends only on the top level's ports.
module mmm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    // A rescaled word always comes from a throttle above idle, so never zero.
    a_resc_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[85:78] != 8'd0))
        else $error("rescaled word with zero throttle");

    // The fill bits above the throttle stay zero.
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[87:86] == 2'b00))
        else $error("nonzero fill bits in result word");

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result word changed");

    // Reset empties the output.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid after reset");
endmodule

bind multirotor_motor_mixer_top mmm_checker u_mmm_checker (.*);
